### hdl/fpm_pkg.sv
// shared types, sizes and twiddle rom for the fft polynomial multiplier
package fpm_pkg;

  localparam int Points   = 32;
  localparam int LgPoints = 5;
  localparam int Capacity = Points / 2;
  localparam int IdxW     = LgPoints;
  localparam int AddrW    = LgPoints + 1;
  localparam int MemDepth = 2 * Points;
  localparam int DataW    = 47;
  localparam int FwdW     = 24;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int StageW   = $clog2(LgPoints);
  localparam int BflyW    = LgPoints - 1;
  localparam int TwW      = 6;
  localparam int OutW     = 40;

  typedef struct packed {
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic             clear;
    logic             ext_we;
    logic [AddrW-1:0] ext_addr;
    cplx_t            ext_data;
    logic             rd_en;
    logic [AddrW-1:0] addr_a;
    logic [AddrW-1:0] addr_b;
    logic [TwW-1:0]   tw_idx;
    logic             wide;
    logic             mul_en;
    logic             sum_en;
    logic             wr_top;
    logic             wr_bot;
  } lane_ctl_t;

  function automatic logic signed [16:0] quarter_cos(input logic [4:0] k);
    logic signed [16:0] v;
    case (k)
      5'd0:    v = 17'sd32768;
      5'd1:    v = 17'sd32610;
      5'd2:    v = 17'sd32138;
      5'd3:    v = 17'sd31357;
      5'd4:    v = 17'sd30274;
      5'd5:    v = 17'sd28899;
      5'd6:    v = 17'sd27246;
      5'd7:    v = 17'sd25330;
      5'd8:    v = 17'sd23170;
      5'd9:    v = 17'sd20788;
      5'd10:   v = 17'sd18205;
      5'd11:   v = 17'sd15447;
      5'd12:   v = 17'sd12540;
      5'd13:   v = 17'sd9512;
      5'd14:   v = 17'sd6393;
      5'd15:   v = 17'sd3212;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [16:0] cos_rom(input logic [TwW-1:0] m);
    logic signed [16:0] v;
    if (m <= 6'd16) begin
      v = quarter_cos(5'(m));
    end else if (m <= 6'd32) begin
      v = -quarter_cos(5'(6'd32 - m));
    end else if (m <= 6'd48) begin
      v = -quarter_cos(5'(m - 6'd32));
    end else begin
      v = quarter_cos(5'(7'd64 - 7'(m)));
    end
    return v;
  endfunction

  function automatic logic [IdxW-1:0] bit_rev(input logic [IdxW-1:0] x);
    logic [IdxW-1:0] r;
    for (int k = 0; k < IdxW; k++) begin
      r[IdxW-1-k] = x[k];
    end
    return r;
  endfunction

endpackage

### hdl/fpm_lane.sv
// one transform lane: coefficient memory and a multi-cycle radix-2 butterfly
module fpm_lane import fpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_ctl_t ctl_i,
  output cplx_t     rd_a_o,
  output logic      sat_o
);

  logic [2*DataW-1:0]  mem_q [MemDepth];
  logic [MemDepth-1:0] valid_q;
  cplx_t               a_q, b_q;
  logic signed [63:0]  pp0_q, pp1_q, pp2_q, pp3_q;
  logic signed [49:0]  tr_q, ti_q;
  logic signed [16:0]  wr, wi;
  logic signed [63:0]  dr, di;
  logic signed [50:0]  top_re, top_im, bot_re, bot_im;
  cplx_t               top_v, bot_v;
  logic                top_sat, bot_sat;
  logic                we;
  logic [AddrW-1:0]    waddr;
  cplx_t               wdata;

  assign wr = cos_rom(ctl_i.tw_idx);
  assign wi = cos_rom(ctl_i.tw_idx + 6'd48);

  function automatic logic signed [DataW-1:0] sat_bf(input logic signed [50:0] x,
                                                     input logic wide);
    logic signed [DataW-1:0] r;
    if (wide) begin
      if (x > 51'sd70368744177663) r = 47'sd70368744177663;
      else if (x < -51'sd70368744177664) r = -47'sd70368744177664;
      else r = x[DataW-1:0];
    end else begin
      if (x > 51'sd8388607) r = 47'sd8388607;
      else if (x < -51'sd8388608) r = -47'sd8388608;
      else r = x[DataW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    dr      = pp0_q - pp1_q + 64'sd16384;
    di      = pp2_q + pp3_q + 64'sd16384;
    top_re  = 51'(a_q.re) + 51'(tr_q);
    top_im  = 51'(a_q.im) + 51'(ti_q);
    bot_re  = 51'(a_q.re) - 51'(tr_q);
    bot_im  = 51'(a_q.im) - 51'(ti_q);
    top_v.re = sat_bf(top_re, ctl_i.wide);
    top_v.im = sat_bf(top_im, ctl_i.wide);
    bot_v.re = sat_bf(bot_re, ctl_i.wide);
    bot_v.im = sat_bf(bot_im, ctl_i.wide);
    top_sat = (51'(top_v.re) != top_re) || (51'(top_v.im) != top_im);
    bot_sat = (51'(bot_v.re) != bot_re) || (51'(bot_v.im) != bot_im);
    we      = ctl_i.ext_we | ctl_i.wr_top | ctl_i.wr_bot;
    if (ctl_i.ext_we) begin
      waddr = ctl_i.ext_addr;
      wdata = ctl_i.ext_data;
    end else if (ctl_i.wr_top) begin
      waddr = ctl_i.addr_a;
      wdata = top_v;
    end else begin
      waddr = ctl_i.addr_b;
      wdata = bot_v;
    end
  end

  assign sat_o  = (ctl_i.wr_top & top_sat) | (ctl_i.wr_bot & bot_sat);
  assign rd_a_o = a_q;

  // empty entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.clear) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (ctl_i.rd_en) begin
      a_q <= valid_q[ctl_i.addr_a] ? cplx_t'(mem_q[ctl_i.addr_a]) : '0;
      b_q <= valid_q[ctl_i.addr_b] ? cplx_t'(mem_q[ctl_i.addr_b]) : '0;
    end
    if (ctl_i.mul_en) begin
      pp0_q <= b_q.re * wr;
      pp1_q <= b_q.im * wi;
      pp2_q <= b_q.re * wi;
      pp3_q <= b_q.im * wr;
    end
    if (ctl_i.sum_en) begin
      tr_q <= 50'(dr >>> 15);
      ti_q <= 50'(di >>> 15);
    end
  end

endmodule

### hdl/fpm_merge.sv
// pointwise spectrum product of the two lanes, saturated to the wide format
module fpm_merge import fpm_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  cplx_t a_i,
  input  cplx_t b_i,
  output cplx_t res_o,
  output logic  sat_o
);

  logic signed [47:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [48:0] sr, si;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= $signed(a_i.re[FwdW-1:0]) * $signed(b_i.re[FwdW-1:0]);
      p1_q <= $signed(a_i.im[FwdW-1:0]) * $signed(b_i.im[FwdW-1:0]);
      p2_q <= $signed(a_i.re[FwdW-1:0]) * $signed(b_i.im[FwdW-1:0]);
      p3_q <= $signed(a_i.im[FwdW-1:0]) * $signed(b_i.re[FwdW-1:0]);
    end
  end

  always_comb begin
    sr = 49'(p0_q) - 49'(p1_q);
    si = 49'(p2_q) + 49'(p3_q);
    if (sr[48:46] != 3'b000 && sr[48:46] != 3'b111) begin
      res_o.re = sr[48] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      res_o.re = sr[DataW-1:0];
    end
    if (si[48:46] != 3'b000 && si[48:46] != 3'b111) begin
      res_o.im = si[48] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      res_o.im = si[DataW-1:0];
    end
    sat_o = (sr[48:46] != 3'b000 && sr[48:46] != 3'b111) ||
            (si[48:46] != 3'b000 && si[48:46] != 3'b111);
  end

endmodule

### hdl/fft_polynomial_multiplier.sv
// top level: load, two-lane forward fft, pointwise product, inverse fft, output
// Up to 16 coefficient pairs are loaded one beat per cycle; the beat with tlast
// starts a run. Both operands are transformed side by side in two lanes, each
// with its own memory and one butterfly that steps through read, multiply, sum,
// write top and write bottom; a transform is 80 butterflies. The pointwise
// product reads, multiplies and writes each point, then the inverse transform
// runs on one lane, a saturation scan follows, and 32 product beats are sent
// as the sink takes them. The input is held off until the last product beat of
// a run is taken. overflow_flag is the same on every beat of a run.
module fft_polynomial_multiplier import fpm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // lhs_real, lhs_imag, rhs_real, rhs_imag
  input  logic         s_axis_tlast,  // final_item
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata,  // prod_real, prod_imag, degree_index, zero pad
  output logic         m_axis_tlast,  // last_coeff
  output logic         m_axis_tuser   // overflow_flag
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_BF_RD    = 14'b00000000000010,
    S_BF_MUL   = 14'b00000000000100,
    S_BF_SUM   = 14'b00000000001000,
    S_BF_WRA   = 14'b00000000010000,
    S_BF_WRB   = 14'b00000000100000,
    S_PW_RD    = 14'b00000001000000,
    S_PW_MUL   = 14'b00000010000000,
    S_PW_WR    = 14'b00000100000000,
    S_CHK_RD   = 14'b00001000000000,
    S_CHK      = 14'b00010000000000,
    S_OUT_RD   = 14'b00100000000000,
    S_OUT_LD   = 14'b01000000000000,
    S_OUT_WAIT = 14'b10000000000000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              drop_q, drop_d;
  logic              sat_q, sat_d;
  logic              inv_q, inv_d;
  logic [StageW-1:0] stage_q, stage_d;
  logic [BflyW-1:0]  bf_q, bf_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              ovalid_q, ovalid_d;
  logic [OutW-1:0]   ore_q, oim_q;
  logic [IdxW-1:0]   odeg_q;
  logic              olast_q, oflag_q;

  lane_ctl_t         ctl_a, ctl_b;
  cplx_t             rd_a, rd_b, pw_res;
  logic              sat_a, sat_b, pw_sat;
  logic              in_beat;
  logic [IdxW-1:0]   half_mask, j_idx, grp, bfa, bfb, ridx;
  logic              bank;
  cplx_t             load_v;
  logic signed [47:0] rre, rim;
  logic [OutW-1:0]   fre, fim;
  logic              fsat;

  fpm_lane u_lane_a (.clk_i, .rst_ni, .ctl_i(ctl_a), .rd_a_o(rd_a), .sat_o(sat_a));
  fpm_lane u_lane_b (.clk_i, .rst_ni, .ctl_i(ctl_b), .rd_a_o(rd_b), .sat_o(sat_b));

  fpm_merge u_merge (
    .clk_i, .en_i(state_q == S_PW_MUL), .a_i(rd_a), .b_i(rd_b),
    .res_o(pw_res), .sat_o(pw_sat)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid & s_axis_tready;
  assign bank          = inv_q;

  always_comb begin
    half_mask = IdxW'((1 << stage_q) - 1);
    j_idx     = IdxW'(bf_q) & half_mask;
    grp       = IdxW'(bf_q) >> stage_q;
    bfa       = (grp << (stage_q + 1'b1)) | j_idx;
    bfb       = bfa | (IdxW'(1) << stage_q);
    ridx      = IdxW'(~idx_q + 1'b1);
    load_v.re = DataW'($signed(s_axis_tdata[15:0]));
    load_v.im = DataW'($signed(s_axis_tdata[31:16]));
  end

  // final divide with rounding and 40-bit saturation
  always_comb begin
    rre  = ($signed({rd_a.re[DataW-1], rd_a.re}) + 48'sd16) >>> LgPoints;
    rim  = ($signed({rd_a.im[DataW-1], rd_a.im}) + 48'sd16) >>> LgPoints;
    fsat = 1'b0;
    if (rre[47:39] != 9'h000 && rre[47:39] != 9'h1ff) begin
      fre  = rre[47] ? {1'b1, {(OutW-1){1'b0}}} : {1'b0, {(OutW-1){1'b1}}};
      fsat = 1'b1;
    end else begin
      fre = rre[OutW-1:0];
    end
    if (rim[47:39] != 9'h000 && rim[47:39] != 9'h1ff) begin
      fim  = rim[47] ? {1'b1, {(OutW-1){1'b0}}} : {1'b0, {(OutW-1){1'b1}}};
      fsat = 1'b1;
    end else begin
      fim = rim[OutW-1:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    drop_d   = drop_q;
    sat_d    = sat_q | sat_a | (sat_b & ~inv_q);
    inv_d    = inv_q;
    stage_d  = stage_q;
    bf_d     = bf_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q;

    ctl_a          = '0;
    ctl_a.addr_a   = {bank, bfa};
    ctl_a.addr_b   = {bank, bfb};
    ctl_a.tw_idx   = TwW'(j_idx) << (LgPoints - stage_q);
    ctl_a.wide     = inv_q;
    ctl_a.ext_addr = {1'b0, bit_rev(IdxW'(cnt_q))};
    ctl_a.ext_data = load_v;

    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (cnt_q < CntW'(Capacity)) begin
            ctl_a.ext_we = 1'b1;
            cnt_d        = cnt_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = S_BF_RD;
            stage_d = '0;
            bf_d    = '0;
            inv_d   = 1'b0;
            sat_d   = 1'b0;
          end
        end
      end
      S_BF_RD: begin
        ctl_a.rd_en = 1'b1;
        state_d     = S_BF_MUL;
      end
      S_BF_MUL: begin
        ctl_a.mul_en = 1'b1;
        state_d      = S_BF_SUM;
      end
      S_BF_SUM: begin
        ctl_a.sum_en = 1'b1;
        state_d      = S_BF_WRA;
      end
      S_BF_WRA: begin
        ctl_a.wr_top = 1'b1;
        state_d      = S_BF_WRB;
      end
      S_BF_WRB: begin
        ctl_a.wr_bot = 1'b1;
        bf_d         = bf_q + 1'b1;
        state_d      = S_BF_RD;
        if (bf_q == BflyW'(Points / 2 - 1)) begin
          if (stage_q == StageW'(LgPoints - 1)) begin
            idx_d   = '0;
            state_d = inv_q ? S_CHK_RD : S_PW_RD;
          end else begin
            stage_d = stage_q + 1'b1;
          end
        end
      end
      S_PW_RD: begin
        ctl_a.rd_en  = 1'b1;
        ctl_a.addr_a = {1'b0, idx_q};
        state_d      = S_PW_MUL;
      end
      S_PW_MUL: begin
        state_d = S_PW_WR;
      end
      S_PW_WR: begin
        ctl_a.ext_we   = 1'b1;
        ctl_a.ext_addr = {1'b1, bit_rev(idx_q)};
        ctl_a.ext_data = pw_res;
        sat_d          = sat_q | pw_sat;
        idx_d          = idx_q + 1'b1;
        state_d        = S_PW_RD;
        if (idx_q == IdxW'(Points - 1)) begin
          inv_d   = 1'b1;
          stage_d = '0;
          bf_d    = '0;
          state_d = S_BF_RD;
        end
      end
      S_CHK_RD: begin
        ctl_a.rd_en  = 1'b1;
        ctl_a.addr_a = {1'b1, ridx};
        state_d      = S_CHK;
      end
      S_CHK: begin
        sat_d   = sat_q | fsat;
        idx_d   = idx_q + 1'b1;
        state_d = (idx_q == IdxW'(Points - 1)) ? S_OUT_RD : S_CHK_RD;
      end
      S_OUT_RD: begin
        ctl_a.rd_en  = 1'b1;
        ctl_a.addr_a = {1'b1, ridx};
        state_d      = S_OUT_LD;
      end
      S_OUT_LD: begin
        ovalid_d = 1'b1;
        state_d  = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (m_axis_tready) begin
          ovalid_d = 1'b0;
          idx_d    = idx_q + 1'b1;
          state_d  = S_OUT_RD;
          if (idx_q == IdxW'(Points - 1)) begin
            ctl_a.clear = 1'b1;
            cnt_d       = '0;
            drop_d      = 1'b0;
            sat_d       = 1'b0;
            inv_d       = 1'b0;
            state_d     = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    ctl_b             = ctl_a;
    ctl_b.ext_data.re = DataW'($signed(s_axis_tdata[47:32]));
    ctl_b.ext_data.im = DataW'($signed(s_axis_tdata[63:48]));
    ctl_b.ext_we      = ctl_a.ext_we & (state_q == S_IDLE);
    ctl_b.wr_top      = ctl_a.wr_top & ~inv_q;
    ctl_b.wr_bot      = ctl_a.wr_bot & ~inv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      drop_q   <= 1'b0;
      sat_q    <= 1'b0;
      inv_q    <= 1'b0;
      stage_q  <= '0;
      bf_q     <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      drop_q   <= drop_d;
      sat_q    <= sat_d;
      inv_q    <= inv_d;
      stage_q  <= stage_d;
      bf_q     <= bf_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT_LD) begin
      ore_q   <= fre;
      oim_q   <= fim;
      odeg_q  <= idx_q;
      olast_q <= (idx_q == IdxW'(Points - 1));
      oflag_q <= drop_q | sat_q;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'b000, odeg_q, oim_q, ore_q};
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = oflag_q;

endmodule

### hdl/fpm_checker.sv
// port-level checks for the fft polynomial multiplier, bound to the top level
module fpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // no loading while a product beat is on offer
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output valid");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  // last beat carries the top degree
  a_last_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[84:80] == 5'd31)
    else $error("last beat with wrong degree");

  a_back_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("not ready for input after run");

  // overflow flag is constant across consecutive beats of a run
  a_flag_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast ##3 m_axis_tvalid
      |-> m_axis_tuser == $past(m_axis_tuser, 3))
    else $error("overflow flag changed within a run");

endmodule

bind fft_polynomial_multiplier fpm_checker u_fpm_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
);
